>>> rtl/artt_pkg.sv
// package for the advertiser rssi tracking table: constants, payload types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package artt_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [15:0] CountMax = 16'hffff;

  typedef enum logic [2:0] {
    KIND_UPDATED  = 3'd0,
    KIND_NEW_FREE = 3'd1,
    KIND_NEW_EVICT = 3'd2,
    KIND_RECORD   = 3'd3,
    KIND_EMPTY    = 3'd4
  } result_kind_e;

  typedef struct packed {
    logic        mode;
    logic [47:0] adv_address;
    logic [7:0]  addr_kind;
    logic [7:0]  event_kind;
    logic signed [7:0] rssi_dbm;
    logic [31:0] now_ms;
    logic [4:0]  max_records;
  } obs_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [47:0] rec_address;
    logic [7:0]  rec_addr_kind;
    logic [7:0]  rec_event_kind;
    logic signed [7:0] rssi_latest;
    logic signed [7:0] rssi_lowest;
    logic signed [7:0] rssi_highest;
    logic signed [15:0] rssi_average_q8;
    logic [15:0] seen_count;
    logic [31:0] seen_time_ms;
    logic [4:0]  occupied_count;
    logic        last_of_run;
  } rec_t;

  // one stored table entry
  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  addr_kind;
    logic [7:0]  event_kind;
    logic signed [7:0] latest;
    logic signed [7:0] lowest;
    logic signed [7:0] highest;
    logic signed [15:0] average;
    logic [15:0] count;
    logic [31:0] seen_time;
  } entry_t;
endpackage
`default_nettype wire

>>> rtl/artt_if.sv
// valid/ready channel interfaces for observe items and result records
// depends on artt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface artt_obs_if;
  logic valid;
  logic ready;
  artt_pkg::obs_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface artt_rec_if;
  logic valid;
  logic ready;
  artt_pkg::rec_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/advertiser_rssi_tracking_table.sv
// advertiser rssi tracking table top level
// depends on artt_pkg and the channel interfaces in artt_if
//
// usage: in_i carries observe or snapshot beats, out_o carries result beats.
// an observe beat scans the 16 slots through the table memory, one read per
// cycle through a registered read port, then reads the chosen slot again and
// writes it back while loading the result; the input is ready again once
// the result is loaded.
// a snapshot reads all slots once, emitting a record for each occupied slot
// up to the limit and clearing the valid bits. the scan over the entry
// memory, which has one read port and one write port, sets the rate.
// a result beat is held in the output register until taken. while it waits an
// observe finishes its scan and then holds at its write-back, and a snapshot
// pauses its scan; no new input is accepted until the item is done.
// reset clears the valid bits and occupied count at once; the entry memory
// has no reset, an entry's data is only used after being written.
// last_of_run marks the final result of each input beat.
`timescale 1ns / 1ps
`default_nettype none
module advertiser_rssi_tracking_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  artt_obs_if.sink   in_i,
  artt_rec_if.source out_o
);
  localparam int unsigned IdxW = artt_pkg::IdxW;
  localparam int unsigned CntW = artt_pkg::CntW;
  localparam artt_pkg::rec_t EmptyRec = '{
    result_kind: artt_pkg::KIND_EMPTY, last_of_run: 1'b1, default: '0};

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RMW, ST_SNAP, ST_OUT
  } state_e;

  state_e state_q;
  artt_pkg::obs_t req_q;
  logic [artt_pkg::Entries-1:0] valid_q;
  logic [CntW-1:0] total_q;
  logic [CntW-1:0] ptr_q;          // next address to present
  logic            rd_vld_q;       // memory data valid for rd_idx_q
  logic [IdxW-1:0] rd_idx_q;
  logic            hit_f_q, free_f_q, old_f_q;
  logic [IdxW-1:0] hit_q, free_q, old_q;
  logic [31:0]     old_t_q;
  logic [CntW-1:0] written_q, limit_q;
  logic            out_vld_q;
  artt_pkg::rec_t  out_q;
  logic            tgt_rd_q;       // unused flag, cleared on reset and on each input beat

  // entry memory
  artt_pkg::entry_t mem [artt_pkg::Entries];
  artt_pkg::entry_t rd_data_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  artt_pkg::entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_data_q <= mem[raddr];
  end

  wire logic in_take = in_i.valid && in_i.ready;
  wire logic out_take = out_vld_q && out_o.ready;
  wire logic out_free = !out_vld_q || out_take;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;

  // target slot of an observe
  logic [IdxW-1:0] tgt;
  logic [2:0] tkind;
  always_comb begin
    priority if (hit_f_q) begin
      tgt = hit_q; tkind = artt_pkg::KIND_UPDATED;
    end else if (free_f_q) begin
      tgt = free_q; tkind = artt_pkg::KIND_NEW_FREE;
    end else begin
      tgt = old_q; tkind = artt_pkg::KIND_NEW_EVICT;
    end
  end

  // memory read address
  always_comb begin
    if (state_q == ST_SCAN && ptr_q == CntW'(artt_pkg::Entries) && !rd_vld_q) raddr = tgt;
    else if (state_q == ST_RMW) raddr = tgt;
    else if (state_q == ST_SNAP && !out_free) raddr = rd_idx_q;
    else raddr = ptr_q[IdxW-1:0];
  end

  // update arithmetic
  artt_pkg::entry_t upd;
  logic signed [17:0] avg_sum;
  logic signed [17:0] avg_div;
  logic signed [7:0] r;
  logic [CntW-1:0] new_total;
  always_comb begin
    r = req_q.rssi_dbm;
    avg_sum = 18'(rd_data_q.average) * 18'sd3 + {{2{r[7]}}, r, 8'd0} + 18'sd2;
    avg_div = (avg_sum < 0) ? -((-avg_sum) >>> 2) : (avg_sum >>> 2);
    upd = rd_data_q;
    upd.event_kind = req_q.event_kind;
    upd.latest = r;
    upd.seen_time = req_q.now_ms;
    if (hit_f_q) begin
      if (r < rd_data_q.lowest) upd.lowest = r;
      if (r > rd_data_q.highest) upd.highest = r;
      upd.average = avg_div[15:0];
      if (rd_data_q.count != artt_pkg::CountMax) upd.count = rd_data_q.count + 16'd1;
    end else begin
      upd.address = req_q.adv_address;
      upd.addr_kind = req_q.addr_kind;
      upd.lowest = r;
      upd.highest = r;
      upd.average = {r, 8'd0};
      upd.count = 16'd1;
    end
    new_total = (hit_f_q || !free_f_q) ? total_q : total_q + CntW'(1);
    we = (state_q == ST_RMW) && out_free;
    waddr = tgt;
    wdata = upd;
  end

  // result register loads
  logic out_load;
  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      ST_RMW:  out_load = out_free;
      ST_SNAP: out_load = rd_vld_q && out_free && valid_q[rd_idx_q] && (written_q < limit_q);
      ST_OUT:  out_load = (written_q == '0) && out_free;
      default: out_load = 1'b0;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  wire logic [IdxW-1:0] last_idx = IdxW'(artt_pkg::Entries - 1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      total_q <= '0;
      ptr_q <= '0;
      rd_vld_q <= 1'b0;
      tgt_rd_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            req_q <= in_i.payload;
            limit_q <= (in_i.payload.max_records > 5'd16) ? CntW'(16)
                       : CntW'(in_i.payload.max_records);
            written_q <= '0;
            hit_f_q <= 1'b0; free_f_q <= 1'b0; old_f_q <= 1'b0;
            ptr_q <= '0;
            rd_vld_q <= 1'b0;
            tgt_rd_q <= 1'b0;
            state_q <= in_i.payload.mode ? ST_SNAP : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // compare the entry read last cycle
          if (rd_vld_q) begin
            if (valid_q[rd_idx_q]) begin
              if (!hit_f_q && rd_data_q.addr_kind == req_q.addr_kind
                  && rd_data_q.address == req_q.adv_address) begin
                hit_f_q <= 1'b1; hit_q <= rd_idx_q;
              end
              if (!old_f_q || rd_data_q.seen_time < old_t_q) begin
                old_f_q <= 1'b1; old_q <= rd_idx_q; old_t_q <= rd_data_q.seen_time;
              end
            end else if (!free_f_q) begin
              free_f_q <= 1'b1; free_q <= rd_idx_q;
            end
          end
          if (ptr_q != CntW'(artt_pkg::Entries)) begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= ptr_q[IdxW-1:0];
            ptr_q <= ptr_q + CntW'(1);
          end else if (rd_vld_q) begin
            rd_vld_q <= 1'b0;      // last compare done, target read issued next
          end else begin
            state_q <= ST_RMW;     // target entry read this edge
          end
        end
        ST_RMW: begin
          if (out_free) begin
            valid_q[tgt] <= 1'b1;
            total_q <= new_total;
            out_q.result_kind <= tkind;
            out_q.rec_address <= upd.address;
            out_q.rec_addr_kind <= upd.addr_kind;
            out_q.rec_event_kind <= upd.event_kind;
            out_q.rssi_latest <= upd.latest;
            out_q.rssi_lowest <= upd.lowest;
            out_q.rssi_highest <= upd.highest;
            out_q.rssi_average_q8 <= upd.average;
            out_q.seen_count <= upd.count;
            out_q.seen_time_ms <= upd.seen_time;
            out_q.occupied_count <= 5'(new_total);
            out_q.last_of_run <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_SNAP: begin
          // data for rd_idx_q is current when rd_vld_q; raddr holds while stalled
          if (rd_vld_q && out_free) begin
            if (valid_q[rd_idx_q]) begin
              valid_q[rd_idx_q] <= 1'b0;
              if (written_q < limit_q) begin
                written_q <= written_q + CntW'(1);
                out_q.result_kind <= artt_pkg::KIND_RECORD;
                out_q.rec_address <= rd_data_q.address;
                out_q.rec_addr_kind <= rd_data_q.addr_kind;
                out_q.rec_event_kind <= rd_data_q.event_kind;
                out_q.rssi_latest <= rd_data_q.latest;
                out_q.rssi_lowest <= rd_data_q.lowest;
                out_q.rssi_highest <= rd_data_q.highest;
                out_q.rssi_average_q8 <= rd_data_q.average;
                out_q.seen_count <= rd_data_q.count;
                out_q.seen_time_ms <= rd_data_q.seen_time;
                out_q.occupied_count <= '0;
                // last if no later valid slot will be emitted
                out_q.last_of_run <= (written_q + CntW'(1) == limit_q) ||
                  ((valid_q >> rd_idx_q) >> 1) == '0;
              end
            end
            if (rd_idx_q == last_idx) begin
              rd_vld_q <= 1'b0;
              state_q <= ST_OUT;
            end
          end
          if (out_free && ptr_q != CntW'(artt_pkg::Entries)) begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= ptr_q[IdxW-1:0];
            ptr_q <= ptr_q + CntW'(1);
          end
        end
        ST_OUT: begin
          total_q <= '0;
          if (written_q != '0) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q <= EmptyRec;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // occupancy count always tracks the valid bits outside a step
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> total_q == CntW'($countones(valid_q)))
    else $error("occupied count out of step with valid bits");
  // a snapshot leaves the table empty
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> valid_q == '0)
    else $error("snapshot did not clear table");
  // no more records than the limit
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    written_q <= limit_q || state_q == ST_SCAN || state_q == ST_RMW || state_q == ST_IDLE)
    else $error("snapshot emitted past limit");
  // observe writes only when the result register is free
  a_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !out_vld_q || out_o.ready)
    else $error("observe result overwrote a pending beat");
endmodule
`default_nettype wire
